// File: rtl/core/i2c_master_transfer_sequencer_defines.svh
// Assertion macros used by the checker of the sequencer.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication, disabled while reset is low.
`define SEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

// File: rtl/core/i2cms_pkg.sv
package i2cms_pkg;

    localparam int CountBits = 16;

    typedef enum logic [1:0] {
        CMD_START_READ  = 2'd0,
        CMD_START_WRITE = 2'd1,
        CMD_EVENT       = 2'd2,
        CMD_CANCEL      = 2'd3
    } t_cmd;

    localparam logic [7:0] CW_START   = 8'hF0;
    localparam logic [7:0] CW_RX      = 8'hE0;
    localparam logic [7:0] CW_RX_NACK = 8'hE8;
    localparam logic [7:0] CW_STOP    = 8'h80;
    localparam logic [7:0] ST_ARB_LOST = 8'h10;
    localparam logic [7:0] ST_NACK     = 8'h01;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  slave_address;
        logic [15:0] byte_count;
        logic [7:0]  bus_status;
        logic [7:0]  received_byte;
        logic [7:0]  send_byte;
    } t_item;

    typedef struct packed {
        logic        ctrl_write;
        logic [7:0]  ctrl_value;
        logic        data_write;
        logic [7:0]  data_value;
        logic        data_read;
        logic        rx_valid;
        logic [7:0]  rx_data;
        logic        done_res;
        logic [15:0] done_count;
    } t_result;

endpackage

// File: rtl/core/i2cms_in_reg.sv
module i2cms_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  i2cms_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_ready,
    output logic            o_valid,
    output i2cms_pkg::t_item o_item
);
    import i2cms_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The slot frees up in the same cycle its request moves on.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// File: rtl/core/i2cms_step.sv
module i2cms_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  i2cms_pkg::t_item   i_item,
    output i2cms_pkg::t_result o_result
);
    import i2cms_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_is_read, n_is_read;
    logic                 r_first, n_first;
    logic [CountBits-1:0] r_remaining, n_remaining;
    logic [CountBits-1:0] r_requested, n_requested;

    logic [CountBits-1:0] cnt;
    logic [CountBits-1:0] rem_dec;
    t_result              res;

    assign cnt     = CountBits'(i_item.byte_count);
    assign rem_dec = r_remaining - CountBits'(1);

    always_comb begin
        n_busy      = r_busy;
        n_is_read   = r_is_read;
        n_first     = r_first;
        n_remaining = r_remaining;
        n_requested = r_requested;
        res         = '0;
        unique case (i_item.cmd)
            CMD_START_READ, CMD_START_WRITE: begin
                if (!r_busy) begin
                    n_is_read   = (i_item.cmd == CMD_START_READ);
                    n_requested = cnt;
                    n_remaining = cnt;
                    n_first     = 1'b1;
                    if (n_is_read && (cnt == '0)) begin
                        // Nothing to read: report completion with no bus traffic.
                        res.done_res = 1'b1;
                        n_busy       = 1'b0;
                    end else begin
                        n_busy         = 1'b1;
                        res.ctrl_write = 1'b1;
                        res.ctrl_value = CW_START;
                        res.data_write = 1'b1;
                        res.data_value = n_is_read ? (i_item.slave_address | 8'h01)
                                                   : i_item.slave_address;
                    end
                end
            end
            CMD_CANCEL: begin
                if (r_busy) begin
                    res.ctrl_write = 1'b1;
                    res.ctrl_value = CW_STOP;
                    res.done_res   = 1'b1;
                    res.done_count = 16'(r_requested - r_remaining);
                    n_busy         = 1'b0;
                end
            end
            CMD_EVENT: begin
                if (r_busy) begin
                    if ((i_item.bus_status & ST_ARB_LOST) != 8'h00) begin
                        res.ctrl_write = 1'b1;
                        res.ctrl_value = CW_STOP;
                        res.done_res   = 1'b1;
                        res.done_count = 16'(r_requested - r_remaining);
                        n_busy         = 1'b0;
                    end else if (r_is_read) begin
                        if (r_first) begin
                            // Dummy read after the address phase starts reception.
                            n_first        = 1'b0;
                            res.ctrl_write = 1'b1;
                            res.ctrl_value = (r_remaining == CountBits'(1)) ? CW_RX_NACK
                                                                            : CW_RX;
                            res.data_read  = 1'b1;
                        end else begin
                            if (r_remaining == CountBits'(1)) begin
                                res.ctrl_write = 1'b1;
                                res.ctrl_value = CW_STOP;
                            end else if (r_remaining == CountBits'(2)) begin
                                res.ctrl_write = 1'b1;
                                res.ctrl_value = CW_RX_NACK;
                            end
                            res.data_read = 1'b1;
                            res.rx_valid  = 1'b1;
                            res.rx_data   = i_item.received_byte;
                            n_remaining   = rem_dec;
                            if (rem_dec == '0) begin
                                res.done_res   = 1'b1;
                                res.done_count = 16'(r_requested - rem_dec);
                                n_busy         = 1'b0;
                            end
                        end
                    end else begin
                        n_first = 1'b0;
                        if ((r_remaining == '0) ||
                            ((i_item.bus_status & ST_NACK) != 8'h00)) begin
                            res.ctrl_write = 1'b1;
                            res.ctrl_value = CW_STOP;
                            res.done_res   = 1'b1;
                            res.done_count = 16'(r_requested - r_remaining);
                            n_busy         = 1'b0;
                        end else begin
                            res.data_write = 1'b1;
                            res.data_value = i_item.send_byte;
                            n_remaining    = rem_dec;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_is_read   <= 1'b0;
            r_first     <= 1'b0;
            r_remaining <= '0;
            r_requested <= '0;
        end else if (i_advance) begin
            r_busy      <= n_busy;
            r_is_read   <= n_is_read;
            r_first     <= n_first;
            r_remaining <= n_remaining;
            r_requested <= n_requested;
        end
    end

    assign o_result = res;
endmodule

// File: rtl/core/i2cms_out_reg.sv
module i2cms_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  i2cms_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_can_load,
    output logic               o_valid,
    output i2cms_pkg::t_result o_result
);
    import i2cms_pkg::*;

    logic    r_valid;
    t_result r_result;

    // A new result may replace the held one in the cycle it is taken.
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

// File: rtl/core/i2c_master_transfer_sequencer.sv
// A request is captured in the input register, then moves on into the result register,
// where it is offered as a result until the consumer takes it.
// Throughput: one request per cycle while the consumer does not stall.
// Reset (i_rst_n low at a clock edge) empties both pipeline registers and leaves
// the sequencer idle with no transfer in progress and all counters at zero.
module i2c_master_transfer_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_slave_address,
    input  logic [15:0] i_byte_count,
    input  logic [7:0]  i_bus_status,
    input  logic [7:0]  i_received_byte,
    input  logic [7:0]  i_send_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ctrl_write,
    output logic [7:0]  o_ctrl_value,
    output logic        o_data_write,
    output logic [7:0]  o_data_value,
    output logic        o_data_read,
    output logic        o_rx_valid,
    output logic [7:0]  o_rx_data,
    output logic        o_done_res,
    output logic [15:0] o_done_count
);
    import i2cms_pkg::*;

    // Each request is captured in an input register. When the result register
    // can take a value, the request moves on: the transfer state is updated and
    // the matching result is written into the result register in that same
    // edge. Both registers can drain and fill in the same cycle, so a stalled consumer
    // only backs up the pipeline, it never drops or repeats a request.

    t_item   in_item;
    t_item   q_item;
    logic    q_valid;
    logic    advance;
    logic    out_can_load;
    t_result step_result;
    t_result out_result;

    assign in_item.cmd           = t_cmd'(i_cmd);
    assign in_item.slave_address = i_slave_address;
    assign in_item.byte_count    = i_byte_count;
    assign in_item.bus_status    = i_bus_status;
    assign in_item.received_byte = i_received_byte;
    assign in_item.send_byte     = i_send_byte;

    // A held request advances whenever the result slot is free or being emptied.
    assign advance = q_valid && out_can_load;

    i2cms_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (o_in_ready),
        .o_valid   (q_valid),
        .o_item    (q_item)
    );

    // Transfer state lives here and only changes when a request advances.
    i2cms_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (q_item),
        .o_result  (step_result)
    );

    i2cms_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (step_result),
        .i_ready    (i_out_ready),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .o_result   (out_result)
    );

    assign o_ctrl_write = out_result.ctrl_write;
    assign o_ctrl_value = out_result.ctrl_value;
    assign o_data_write = out_result.data_write;
    assign o_data_value = out_result.data_value;
    assign o_data_read  = out_result.data_read;
    assign o_rx_valid   = out_result.rx_valid;
    assign o_rx_data    = out_result.rx_data;
    assign o_done_res   = out_result.done_res;
    assign o_done_count = out_result.done_count;
endmodule

// File: rtl/core/i2cms_checker.sv
`include "i2c_master_transfer_sequencer_defines.svh"

module i2cms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_ctrl_write,
    input logic [7:0]  o_ctrl_value,
    input logic        o_data_write,
    input logic        o_data_read,
    input logic        o_rx_valid,
    input logic        o_done_res,
    input logic [15:0] o_done_count
);
    // A received byte is only delivered on a data register read.
    `SEQ_ASSERT_SAME(a_rx_needs_read, i_clk, i_rst_n, o_out_valid && o_rx_valid, o_data_read)

    // Ending a transfer never coincides with pushing a data byte.
    `SEQ_ASSERT_SAME(a_done_no_write, i_clk, i_rst_n, o_out_valid && o_done_res, !o_data_write)

    // An idle control strobe carries a zero control word.
    `SEQ_ASSERT_SAME(a_ctrl_zero, i_clk, i_rst_n, o_out_valid && !o_ctrl_write,
                     o_ctrl_value == 8'h00)

    // A stalled result holds its strobe and count.
    `SEQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
                     o_out_valid && $stable(o_done_res) && $stable(o_done_count))
endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import i2cms_pkg::*;

    // One row of the directed table. When pinned is set, the row carries a
    // hand-written expectation that replaces the predicted result.
    typedef struct {
        t_item   item;
        bit      pinned;
        t_result want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_cmd;
    logic [7:0]  i_slave_address;
    logic [15:0] i_byte_count;
    logic [7:0]  i_bus_status;
    logic [7:0]  i_received_byte;
    logic [7:0]  i_send_byte;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_ctrl_write;
    logic [7:0]  o_ctrl_value;
    logic        o_data_write;
    logic [7:0]  o_data_value;
    logic        o_data_read;
    logic        o_rx_valid;
    logic [7:0]  o_rx_data;
    logic        o_done_res;
    logic [15:0] o_done_count;

    // Shadow copy of the transfer state, advanced once per accepted request.
    bit          xfer_busy;
    bit          xfer_is_read;
    bit          xfer_first_event;
    logic [15:0] xfer_remaining;
    logic [15:0] xfer_requested;

    // Bus actions still owed by the sequencer, oldest first.
    t_result     owed_actions[$];
    t_row        directed_rows[$];
    int unsigned mismatch_count;
    // While calm is set, neither the sender nor the receiver inserts idle cycles.
    bit          calm;

    i2c_master_transfer_sequencer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_slave_address (i_slave_address),
        .i_byte_count    (i_byte_count),
        .i_bus_status    (i_bus_status),
        .i_received_byte (i_received_byte),
        .i_send_byte     (i_send_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ctrl_write    (o_ctrl_write),
        .o_ctrl_value    (o_ctrl_value),
        .o_data_write    (o_data_write),
        .o_data_value    (o_data_value),
        .o_data_read     (o_data_read),
        .o_rx_valid      (o_rx_valid),
        .o_rx_data       (o_rx_data),
        .o_done_res      (o_done_res),
        .o_done_count    (o_done_count)
    );

    // The clock runs with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Builds a result from its fields in port order; used for pinned rows.
    function automatic t_result outcome(input logic cw, input logic [7:0] cv,
                                        input logic dw, input logic [7:0] dv,
                                        input logic dr, input logic rv,
                                        input logic [7:0] rd, input logic dn,
                                        input logic [15:0] dc);
        t_result r;
        r.ctrl_write = cw;
        r.ctrl_value = cv;
        r.data_write = dw;
        r.data_value = dv;
        r.data_read  = dr;
        r.rx_valid   = rv;
        r.rx_data    = rd;
        r.done_res   = dn;
        r.done_count = dc;
        return r;
    endfunction

    // Marks the transfer as finished and reports how many bytes moved.
    function automatic void end_transfer(inout t_result r);
        r.done_res   = 1'b1;
        r.done_count = xfer_requested - xfer_remaining;
        xfer_busy    = 1'b0;
    endfunction

    // Computes the bus actions that one request causes and advances the
    // shadow state. Strobed-off fields stay zero.
    function automatic t_result sequencer_step(input t_item it);
        t_result r;
        r = '0;
        case (it.cmd)
            CMD_START_READ, CMD_START_WRITE: begin
                if (!xfer_busy) begin
                    xfer_is_read     = (it.cmd == CMD_START_READ);
                    xfer_requested   = it.byte_count;
                    xfer_remaining   = it.byte_count;
                    xfer_first_event = 1'b1;
                    if (xfer_is_read && it.byte_count == 16'd0) begin
                        // A read of no bytes finishes without touching the bus.
                        end_transfer(r);
                    end else begin
                        xfer_busy    = 1'b1;
                        r.ctrl_write = 1'b1;
                        r.ctrl_value = CW_START;
                        r.data_write = 1'b1;
                        r.data_value = xfer_is_read ? (it.slave_address | 8'h01)
                                                    : it.slave_address;
                    end
                end
            end
            CMD_CANCEL: begin
                if (xfer_busy) begin
                    r.ctrl_write = 1'b1;
                    r.ctrl_value = CW_STOP;
                    end_transfer(r);
                end
            end
            default: begin
                if (!xfer_busy) begin
                    // Events with no transfer running are ignored.
                end else if ((it.bus_status & ST_ARB_LOST) != 8'h00) begin
                    r.ctrl_write = 1'b1;
                    r.ctrl_value = CW_STOP;
                    end_transfer(r);
                end else if (xfer_is_read) begin
                    if (xfer_first_event) begin
                        // The first event after the address only arms reception.
                        xfer_first_event = 1'b0;
                        r.ctrl_write = 1'b1;
                        r.ctrl_value = (xfer_remaining == 16'd1) ? CW_RX_NACK : CW_RX;
                        r.data_read  = 1'b1;
                    end else begin
                        if (xfer_remaining == 16'd1) begin
                            r.ctrl_write = 1'b1;
                            r.ctrl_value = CW_STOP;
                        end else if (xfer_remaining == 16'd2) begin
                            r.ctrl_write = 1'b1;
                            r.ctrl_value = CW_RX_NACK;
                        end
                        r.data_read = 1'b1;
                        r.rx_valid  = 1'b1;
                        r.rx_data   = it.received_byte;
                        xfer_remaining = xfer_remaining - 16'd1;
                        if (xfer_remaining == 16'd0) begin
                            end_transfer(r);
                        end
                    end
                end else begin
                    xfer_first_event = 1'b0;
                    if (xfer_remaining == 16'd0 || (it.bus_status & ST_NACK) != 8'h00) begin
                        r.ctrl_write = 1'b1;
                        r.ctrl_value = CW_STOP;
                        end_transfer(r);
                    end else begin
                        r.data_write = 1'b1;
                        r.data_value = it.send_byte;
                        xfer_remaining = xfer_remaining - 16'd1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Random request shaped by the current transfer state: mostly complete
    // transfers with random payload, with aborts, cancels and noise mixed in.
    function automatic t_item random_request();
        t_item       it;
        int unsigned pick;
        int unsigned size_pick;
        it.cmd           = t_cmd'($urandom_range(3));
        it.slave_address = 8'($urandom);
        it.byte_count    = 16'($urandom);
        it.bus_status    = 8'($urandom);
        it.received_byte = 8'($urandom);
        it.send_byte     = 8'($urandom);
        pick = $urandom_range(99);
        if (!xfer_busy) begin
            if (pick < 88) begin
                it.cmd = pick[0] ? CMD_START_WRITE : CMD_START_READ;
                size_pick = $urandom_range(99);
                // Short transfers dominate; a few take a full 16-bit count.
                if (size_pick < 70) begin
                    it.byte_count = 16'($urandom_range(5));
                end else if (size_pick < 92) begin
                    it.byte_count = 16'($urandom_range(40, 6));
                end
            end
        end else if (pick < 90) begin
            it.cmd = CMD_EVENT;
            it.bus_status = it.bus_status & ~ST_ARB_LOST;
            if (!xfer_is_read) begin
                it.bus_status = it.bus_status & ~ST_NACK;
                if ($urandom_range(99) < 5) begin
                    it.bus_status = it.bus_status | ST_NACK;
                end
            end
            if ($urandom_range(99) < 4) begin
                it.bus_status = it.bus_status | ST_ARB_LOST;
            end
        end else if (pick < 94) begin
            it.cmd = CMD_CANCEL;
        end else if (pick < 97) begin
            it.cmd = pick[0] ? CMD_START_WRITE : CMD_START_READ;
        end
        return it;
    endfunction

    task automatic add_row(input t_cmd cmd, input logic [7:0] addr, input logic [15:0] cnt,
                           input logic [7:0] status, input logic [7:0] rx_byte,
                           input logic [7:0] tx_byte, input bit pinned, input t_result want);
        t_row row;
        row.item.cmd           = cmd;
        row.item.slave_address = addr;
        row.item.byte_count    = cnt;
        row.item.bus_status    = status;
        row.item.received_byte = rx_byte;
        row.item.send_byte     = tx_byte;
        row.pinned             = pinned;
        row.want               = want;
        directed_rows.push_back(row);
    endtask

    // Offers one request, entered and left at a falling edge. The request is
    // predicted at the rising edge where it is accepted.
    task automatic put_request(input t_item it, input bit pinned, input t_result want,
                               output t_result predicted);
        while (!calm && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= it.cmd;
        i_slave_address <= it.slave_address;
        i_byte_count    <= it.byte_count;
        i_bus_status    <= it.bus_status;
        i_received_byte <= it.received_byte;
        i_send_byte     <= it.send_byte;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = sequencer_step(it);
        owed_actions.push_back(pinned ? want : predicted);
        @(negedge i_clk);
    endtask

    // Holds the sender off until the sequencer has delivered everything owed.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (owed_actions.size() != 0) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= 20) begin
            $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        end
    endtask

    // The receiver stalls about a third of the time, except in the calm stretch.
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 32);
    end

    // Every accepted result is compared field by field with the oldest owed one.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_actions.size() == 0) begin
                report_mismatch("unexpected result", 16'd0, 16'd0);
            end else begin
                want = owed_actions.pop_front();
                if (o_ctrl_write !== want.ctrl_write)
                    report_mismatch("ctrl_write", o_ctrl_write, want.ctrl_write);
                if (o_ctrl_value !== want.ctrl_value)
                    report_mismatch("ctrl_value", o_ctrl_value, want.ctrl_value);
                if (o_data_write !== want.data_write)
                    report_mismatch("data_write", o_data_write, want.data_write);
                if (o_data_value !== want.data_value)
                    report_mismatch("data_value", o_data_value, want.data_value);
                if (o_data_read !== want.data_read)
                    report_mismatch("data_read", o_data_read, want.data_read);
                if (o_rx_valid !== want.rx_valid)
                    report_mismatch("rx_valid", o_rx_valid, want.rx_valid);
                if (o_rx_data !== want.rx_data)
                    report_mismatch("rx_data", o_rx_data, want.rx_data);
                if (o_done_res !== want.done_res)
                    report_mismatch("done_res", o_done_res, want.done_res);
                if (o_done_count !== want.done_count)
                    report_mismatch("done_count", o_done_count, want.done_count);
            end
        end
    end

    // Hard limit on the run; a correct run ends long before this.
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    initial begin
        t_result     res;
        int unsigned active;
        bit          drained_mid;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_cmd           = CMD_EVENT;
        i_slave_address = 8'h00;
        i_byte_count    = 16'h0000;
        i_bus_status    = 8'h00;
        i_received_byte = 8'h00;
        i_send_byte     = 8'h00;
        calm            = 1'b0;
        mismatch_count  = 0;
        xfer_busy        = 1'b0;
        xfer_is_read     = 1'b0;
        xfer_first_event = 1'b0;
        xfer_remaining   = 16'd0;
        xfer_requested   = 16'd0;

        // Events and cancels with nothing running do nothing at all.
        add_row(CMD_EVENT, 8'h00, 16'd0, 8'h00, 8'h00, 8'h00, 1'b1, '0);
        add_row(CMD_CANCEL, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '0);
        // A read of no bytes ends at once without touching the bus.
        add_row(CMD_START_READ, 8'h54, 16'd0, 8'h00, 8'h00, 8'h00, 1'b1,
                outcome(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 16'd0));
        // A write of no bytes sends start and address, then stops on the first event.
        add_row(CMD_START_WRITE, 8'h00, 16'd0, 8'h00, 8'h00, 8'h00, 1'b1,
                outcome(1'b1, CW_START, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0));
        add_row(CMD_EVENT, 8'h00, 16'd0, 8'h00, 8'h00, 8'h77, 1'b1,
                outcome(1'b1, CW_STOP, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 16'd0));
        // Three-byte read; the address gets its read bit forced.
        add_row(CMD_START_READ, 8'hFE, 16'd3, 8'h00, 8'h00, 8'h00, 1'b1,
                outcome(1'b1, CW_START, 1'b1, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0));
        // A start while busy is dropped.
        add_row(CMD_START_WRITE, 8'h12, 16'd9, 8'h00, 8'h00, 8'h00, 1'b1, '0);
        // The NACK status bit means nothing during a read.
        add_row(CMD_EVENT, 8'h00, 16'd0, ST_NACK, 8'h11, 8'h00, 1'b0, '0);
        add_row(CMD_EVENT, 8'h00, 16'd0, 8'h00, 8'hA5, 8'h00, 1'b0, '0);
        add_row(CMD_EVENT, 8'h00, 16'd0, ST_NACK, 8'h00, 8'h00, 1'b0, '0);
        add_row(CMD_EVENT, 8'h00, 16'd0, 8'h00, 8'hFF, 8'h00, 1'b0, '0);
        // A single-byte read NACKs right away.
        add_row(CMD_START_READ, 8'h01, 16'd1, 8'h00, 8'h00, 8'h00, 1'b1,
                outcome(1'b1, CW_START, 1'b1, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0));
        add_row(CMD_EVENT, 8'h00, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        add_row(CMD_EVENT, 8'h00, 16'd0, 8'h00, 8'h3C, 8'h00, 1'b0, '0);
        // Longest write, cut short by arbitration loss after two bytes.
        add_row(CMD_START_WRITE, 8'hFF, 16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b1,
                outcome(1'b1, CW_START, 1'b1, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0));
        add_row(CMD_EVENT, 8'h00, 16'd0, 8'h00, 8'h00, 8'hFF, 1'b0, '0);
        add_row(CMD_EVENT, 8'h00, 16'd0, 8'h00, 8'hFF, 8'h00, 1'b0, '0);
        add_row(CMD_EVENT, 8'h00, 16'd0, ST_ARB_LOST, 8'h00, 8'h00, 1'b1,
                outcome(1'b1, CW_STOP, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 16'd2));
        // The slave NACKs the second byte of a write.
        add_row(CMD_START_WRITE, 8'hAA, 16'd2, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        add_row(CMD_EVENT, 8'h00, 16'd0, 8'h00, 8'h00, 8'h55, 1'b0, '0);
        add_row(CMD_EVENT, 8'h00, 16'd0, ST_NACK, 8'h00, 8'hC3, 1'b0, '0);
        // Longest read, cancelled by a timeout before any byte arrives.
        add_row(CMD_START_READ, 8'h80, 16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        add_row(CMD_EVENT, 8'h00, 16'd0, 8'hEF, 8'h00, 8'h00, 1'b0, '0);
        add_row(CMD_CANCEL, 8'h00, 16'd0, 8'h00, 8'h00, 8'h00, 1'b1,
                outcome(1'b1, CW_STOP, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 16'd0));
        add_row(CMD_EVENT, 8'h00, 16'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, '0);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            put_request(directed_rows[k].item, directed_rows[k].pinned,
                        directed_rows[k].want, res);
        end
        hold_until_drained();

        // Random part: only requests whose predicted result is not all zero are counted,
        // and a stretch in the middle runs with no idle cycles on either side.
        active = 0;
        drained_mid = 1'b0;
        while (active < 360) begin
            calm = (active >= 150 && active < 250);
            if (active == 300 && !drained_mid) begin
                drained_mid = 1'b1;
                hold_until_drained();
            end
            put_request(random_request(), 1'b0, '0, res);
            if (res != '0) begin
                active++;
            end
        end
        i_in_valid <= 1'b0;

        while (owed_actions.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && owed_actions.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
